// ===== rtl/skl_pkg.sv =====
package skl_pkg;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;
    localparam int DEPTH_DEF = 16;

    // Request codes
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    // Status codes
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_POS  = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    // Broadcast command seen by every cell
    typedef struct packed {
        logic                       ins;
        logic                       rm;
        logic                       asc;
        logic signed [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0]        handle;
    } t_cell_cmd;

endpackage

// ===== rtl/skl_ifs.sv =====
interface skl_req_if;
    import skl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] sort_key;
    logic [HANDLE_W-1:0]     payload_handle;
    logic [POS_W-1:0]        position;
    modport source (output valid, req_type, sort_key, payload_handle, position, input ready);
    modport sink   (input valid, req_type, sort_key, payload_handle, position, output ready);
endinterface

interface skl_rsp_if;
    import skl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [HANDLE_W-1:0]     out_handle;
    logic [CNT_W-1:0]        entry_count;
    modport source (output valid, status, out_key, out_handle, entry_count, input ready);
    modport sink   (input valid, status, out_key, out_handle, entry_count, output ready);
endinterface

interface skl_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/skl_cell.sv =====
module skl_cell (
    input  logic                                i_clk,
    input  skl_pkg::t_cell_cmd                  i_cmd,
    input  logic                                i_occ,
    input  logic                                i_left_ahead,
    input  logic                                i_shift,
    input  logic signed [skl_pkg::KEY_W-1:0]    i_left_key,
    input  logic [skl_pkg::HANDLE_W-1:0]        i_left_handle,
    input  logic signed [skl_pkg::KEY_W-1:0]    i_right_key,
    input  logic [skl_pkg::HANDLE_W-1:0]        i_right_handle,
    output logic signed [skl_pkg::KEY_W-1:0]    o_key,
    output logic [skl_pkg::HANDLE_W-1:0]        o_handle,
    output logic                                o_ahead
);
    import skl_pkg::*;

    logic signed [KEY_W-1:0] r_key, n_key;
    logic [HANDLE_W-1:0]     r_handle, n_handle;

    // Stored key stays in front of the new key, and so did every cell toward the head;
    // the scan stops at the first cell that is not ahead
    assign o_ahead = i_left_ahead && i_occ &&
                     (i_cmd.asc ? (r_key < i_cmd.key) : (i_cmd.key < r_key));

    // Insert: hold, take new entry, or take left neighbor; remove: take right neighbor
    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_cmd.ins && !o_ahead) begin
            if (i_left_ahead) begin
                n_key    = i_cmd.key;
                n_handle = i_cmd.handle;
            end else begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
            end
        end else if (i_cmd.rm && i_shift) begin
            n_key    = i_right_key;
            n_handle = i_right_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_key    = r_key;
    assign o_handle = r_handle;

endmodule

// ===== rtl/sorted_key_list_unit.sv =====
// Sorted key list: a row of DEPTH cells, each holding one key and handle.
// A result is registered at the clock edge that transfers its request.
// Throughput: one request per cycle while the reply side is ready; every cell compares
// against the new key in parallel and shifts to a neighbor in the same cycle.
// Reset (synchronous, active low) empties the list, sets ascending order
// and drops any pending result; cell contents are not cleared.
module sorted_key_list_unit #(
    parameter int DEPTH = skl_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skl_req_if.sink   i_req,
    skl_cfg_if.sink   i_cfg,
    skl_rsp_if.source o_rsp
);
    import skl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]            r_count, n_count;
    logic                     r_asc;
    logic                     r_out_valid;
    logic [1:0]               r_status, n_status;
    logic signed [KEY_W-1:0]  r_out_key, n_out_key;
    logic [HANDLE_W-1:0]      r_out_handle, n_out_handle;
    logic [CNT_W-1:0]         r_out_count;

    logic                     accept;
    logic                     full;
    logic                     pos_ok;
    logic                     do_ins;
    logic                     do_rm;
    logic [IW-1:0]            rd_idx;
    t_req_type                req;
    t_cell_cmd                cmd;

    logic signed [KEY_W-1:0]  cell_key    [DEPTH];
    logic [HANDLE_W-1:0]      cell_handle [DEPTH];
    logic                     cell_ahead  [DEPTH];

    // Request decode
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_req.valid && i_req.ready;
    assign req         = t_req_type'(i_req.req_type);
    assign full        = (r_count == CW'(DEPTH));
    assign pos_ok      = PW'(i_req.position) < PW'(r_count);
    assign do_ins      = accept && (req == REQ_INSERT) && !full;
    assign do_rm       = accept && (req == REQ_REMOVE) && pos_ok;
    assign rd_idx      = IW'(i_req.position);

    assign cmd.ins    = do_ins;
    assign cmd.rm     = do_rm;
    assign cmd.asc    = r_asc;
    assign cmd.key    = i_req.sort_key;
    assign cmd.handle = i_req.payload_handle;

    // Cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                    left_ahead;
        logic signed [KEY_W-1:0] left_key, right_key;
        logic [HANDLE_W-1:0]     left_handle, right_handle;

        if (g == 0) begin : g_head
            assign left_ahead  = 1'b1;
            assign left_key    = i_req.sort_key;
            assign left_handle = i_req.payload_handle;
        end else begin : g_mid
            assign left_ahead  = cell_ahead[g-1];
            assign left_key    = cell_key[g-1];
            assign left_handle = cell_handle[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_key    = cell_key[g];
            assign right_handle = cell_handle[g];
        end else begin : g_body
            assign right_key    = cell_key[g+1];
            assign right_handle = cell_handle[g+1];
        end

        skl_cell u_cell (
            .i_clk          (i_clk),
            .i_cmd          (cmd),
            .i_occ          (CW'(g) < r_count),
            .i_left_ahead   (left_ahead),
            .i_shift        (PW'(g) >= PW'(i_req.position)),
            .i_left_key     (left_key),
            .i_left_handle  (left_handle),
            .i_right_key    (right_key),
            .i_right_handle (right_handle),
            .o_key          (cell_key[g]),
            .o_handle       (cell_handle[g]),
            .o_ahead        (cell_ahead[g])
        );
    end

    // Result and next count
    always_comb begin
        n_count      = r_count;
        n_status     = ST_DONE;
        n_out_key    = '0;
        n_out_handle = '0;
        case (req)
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            REQ_READ, REQ_REMOVE: begin
                if (!pos_ok) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_out_key    = cell_key[rd_idx];
                    n_out_handle = cell_handle[rd_idx];
                    if (req == REQ_REMOVE) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_asc       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_asc <= i_cfg.data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_out_key    <= n_out_key;
            r_out_handle <= n_out_handle;
            r_out_count  <= CNT_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.out_key     = r_out_key;
    assign o_rsp.out_handle  = r_out_handle;
    assign o_rsp.entry_count = r_out_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_rm_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rm |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list");

    a_count_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_out_valid && (r_out_count == CNT_W'(r_count))))
        else $error("result count differs from list count");

    a_ordered_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_ins && (r_count == '0)) |=> (cell_key[0] == $past(i_req.sort_key)))
        else $error("insert into empty list missed the head cell");
`endif

endmodule

// ===== dv/tb_sorted_key_list_unit.sv =====
module tb_sorted_key_list_unit;
    import skl_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_ITEMS   = 80;

    typedef struct {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [HANDLE_W-1:0]     handle;
        logic [CNT_W-1:0]        count;
    } list_reply_t;

    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN
    } phase_kind_t;

    // Shadow copy of the list; predicts one reply per accepted request
    class key_list_scoreboard;
        logic signed [KEY_W-1:0] shadow_keys[LIST_DEPTH];
        logic [HANDLE_W-1:0]     shadow_handles[LIST_DEPTH];
        int                      shadow_count;
        bit                      shadow_ascending;
        list_reply_t             replies_due[$];
        int                      mismatches;

        function new();
            shadow_count     = 0;
            shadow_ascending = 1'b1;
            mismatches       = 0;
        endfunction

        function void set_order(bit asc);
            shadow_ascending = asc;
        endfunction

        function int stored();
            return shadow_count;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void accept_request(t_req_type rq, logic signed [KEY_W-1:0] k,
                                     logic [HANDLE_W-1:0] h, logic [POS_W-1:0] p);
            list_reply_t r;
            int          at;
            r.status = ST_DONE;
            r.key    = '0;
            r.handle = '0;
            case (rq)
                REQ_INSERT: begin
                    if (shadow_count >= LIST_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // new entry goes in front of the first key not strictly ahead
                        at = 0;
                        while (at < shadow_count &&
                               (shadow_ascending ? (shadow_keys[at] < k)
                                                 : (k < shadow_keys[at])))
                            at++;
                        for (int i = shadow_count; i > at; i--) begin
                            shadow_keys[i]    = shadow_keys[i-1];
                            shadow_handles[i] = shadow_handles[i-1];
                        end
                        shadow_keys[at]    = k;
                        shadow_handles[at] = h;
                        shadow_count++;
                    end
                end
                REQ_READ, REQ_REMOVE: begin
                    if (int'(p) >= shadow_count) begin
                        r.status = ST_BAD_POS;
                    end else begin
                        r.key    = shadow_keys[p];
                        r.handle = shadow_handles[p];
                        if (rq == REQ_REMOVE) begin
                            // close the gap behind the removed entry
                            for (int i = p; i + 1 < shadow_count; i++) begin
                                shadow_keys[i]    = shadow_keys[i+1];
                                shadow_handles[i] = shadow_handles[i+1];
                            end
                            shadow_count--;
                        end
                    end
                end
                default: ;
            endcase
            r.count = CNT_W'(shadow_count);
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic signed [KEY_W-1:0] k,
                                  logic [HANDLE_W-1:0] h, logic [CNT_W-1:0] cnt);
            list_reply_t e;
            if (replies_due.size() == 0) begin
                $error("reply with no request outstanding");
                mismatches++;
                return;
            end
            e = replies_due.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                mismatches++;
            end
            if (k !== e.key) begin
                $error("out_key: expected %0d, got %0d", e.key, k);
                mismatches++;
            end
            if (h !== e.handle) begin
                $error("out_handle: expected 0x%08h, got 0x%08h", e.handle, h);
                mismatches++;
            end
            if (cnt !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, cnt);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   gap_pct   = 20;
    int   stall_pct = 20;

    key_list_scoreboard sb = new();

    skl_req_if req_ch ();
    skl_cfg_if cfg_ch ();
    skl_rsp_if rsp_ch ();

    sorted_key_list_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Reply side backpressure in bursts
    initial begin
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(1, 100) <= stall_pct) begin
                hold = $urandom_range(0, 13);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_reply(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_handle,
                           rsp_ch.entry_count);
    end

    // One request transfer, with an optional idle burst ahead of it
    task automatic send_request(t_req_type rq, logic signed [KEY_W-1:0] k,
                                logic [HANDLE_W-1:0] h, logic [POS_W-1:0] p);
        if ($urandom_range(1, 100) <= gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= rq;
        req_ch.sort_key       <= k;
        req_ch.payload_handle <= h;
        req_ch.position       <= p;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.accept_request(rq, k, h, p);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Order register is only touched with nothing in flight
    task automatic write_order(bit asc);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= asc;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        sb.set_order(asc);
        cfg_ch.valid <= 1'b0;
    endtask

    // Keys: extremes, a narrow band that forces ties, or anything
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(KEY_W-1){1'b0}}};
            1:       return {1'b0, {(KEY_W-1){1'b1}}};
            2, 3, 4: return int'($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(phase_kind_t kind, inout int counted);
        int               roll;
        int               cnt;
        t_req_type        rq;
        logic [POS_W-1:0] p;
        cnt  = sb.stored();
        roll = $urandom_range(1, 100);
        if (kind == PH_FILL) begin
            if (roll <= 85)      rq = REQ_INSERT;
            else if (roll <= 95) rq = REQ_READ;
            else                 rq = REQ_REMOVE;
        end else if (kind == PH_DRAIN) begin
            if (roll <= 15)      rq = REQ_INSERT;
            else if (roll <= 45) rq = REQ_READ;
            else                 rq = REQ_REMOVE;
        end else begin
            if (roll <= 40)      rq = REQ_INSERT;
            else if (roll <= 68) rq = REQ_READ;
            else if (roll <= 96) rq = REQ_REMOVE;
            else                 rq = REQ_NONE;
        end
        // mostly occupied positions, some anywhere in the field
        if (cnt > 0 && $urandom_range(1, 100) <= 80)
            p = $urandom_range(0, cnt - 1);
        else
            p = $urandom_range(0, 15);
        send_request(rq, pick_key(), $urandom, p);
        if (rq != REQ_NONE)
            counted++;
    endtask

    initial begin
        int          counted;
        int          phase;
        int          len;
        int          drain_cycles;
        bit          asc;
        phase_kind_t kind;

        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.req_type       <= REQ_NONE;
        req_ch.sort_key       <= '0;
        req_ch.payload_handle <= '0;
        req_ch.position       <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.data           <= 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, extremes, ties, order flip with entries held
        write_order(1'b1);
        send_request(REQ_READ,   '0, '0, 4'd0);
        send_request(REQ_REMOVE, '0, '0, 4'd15);
        send_request(REQ_NONE,   '1, '1, 4'd15);
        send_request(REQ_INSERT, 32'sd0, 32'h0000_0000, 4'd0);
        send_request(REQ_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, 32'hFFFF_FFFF, 4'd0);
        send_request(REQ_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 32'h0000_0001, 4'd0);
        send_request(REQ_INSERT, 32'sd0, 32'h0000_0002, 4'd0);
        send_request(REQ_INSERT, -32'sd1, 32'h0000_0003, 4'd0);
        for (int i = 0; i <= 5; i++)
            send_request(REQ_READ, '0, '0, POS_W'(i));
        send_request(REQ_REMOVE, '0, '0, 4'd4);
        send_request(REQ_REMOVE, '0, '0, 4'd0);
        send_request(REQ_REMOVE, '0, '0, 4'd1);
        send_request(REQ_READ,   '0, '0, 4'd15);
        write_order(1'b0);
        send_request(REQ_INSERT, 32'sd5, 32'h5555_AAAA, 4'd0);
        send_request(REQ_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 32'hAAAA_5555, 4'd0);
        for (int i = 0; i < 3; i++)
            send_request(REQ_READ, '0, '0, POS_W'(i));

        // Random phases; each may flip the order and the traffic pattern
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            if (phase < 2)
                asc = (phase == 0);
            else
                asc = $urandom_range(0, 1);
            write_order(asc);
            if (counted >= RANDOM_ITEMS - CALM_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else if (phase % 4 == 3) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(5, 40);
                stall_pct = $urandom_range(5, 40);
            end
            case (phase % 3)
                0:       kind = PH_FILL;
                1:       kind = PH_MIXED;
                default: kind = PH_DRAIN;
            endcase
            len = $urandom_range(40, 110);
            if (counted < RANDOM_ITEMS - CALM_ITEMS && counted + len > RANDOM_ITEMS - CALM_ITEMS)
                len = RANDOM_ITEMS - CALM_ITEMS - counted;
            repeat (len) begin
                if (counted < RANDOM_ITEMS)
                    random_request(kind, counted);
            end
            phase++;
        end

        // Drain and settle
        req_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d replies never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
